// File: design/nfde_pkg.sv
`timescale 1ns / 1ps

package nfde_pkg;

   // Field widths of the command and result beats
   localparam int KIND_W  = 3;
   localparam int COORD_W = 10;
   localparam int COLOR_W = 4;
   localparam int LW_W    = 11;

   // Shape end coordinates reach pos + span, one bit wider than a coordinate
   localparam int END_W   = COORD_W + 1;

   // Widest linear pixel index: END_W-bit row times LW_W-bit width plus column
   localparam int IDX_W   = 22;

   localparam logic [LW_W-1:0] LINE_WIDTH_RESET = 11'd320;

   // Command codes
   localparam logic [KIND_W-1:0] KIND_POINT   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_HLINE   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_VLINE   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_FILL    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_OUTLINE = 3'd4;
   localparam logic [KIND_W-1:0] KIND_READ    = 3'd5;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
      logic [COORD_W-1:0] span_w;
      logic [COORD_W-1:0] span_h;
      logic [COLOR_W-1:0] color;
   } req_type;

   typedef struct packed {
      logic [COLOR_W-1:0] pixel_value;
      logic               clipped;
   } rsp_type;

endpackage

// File: design/nfde_ram.sv
`timescale 1ns / 1ps

module nfde_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/nibble_framebuffer_draw_engine.sv
`timescale 1ns / 1ps

// Drawing engine over a byte store of STORE_BYTES bytes, two 4-bit pixels per
// byte (even linear index in the low nibble, odd in the high nibble), where a
// pixel (x, y) sits at index y * line_width + x. A command beat draws a point,
// a horizontal or vertical line, a filled rectangle or a rectangle outline,
// or reads one pixel back; each command returns exactly one result beat with
// the pixel read (zero for drawing commands) and a flag raised when any
// addressed pixel fell beyond the store (such pixels are skipped). After
// reset the engine sweeps the store to zero, one byte a cycle, and stalls
// commands meanwhile; line_width writes are taken at any time. Commands run
// one at a time through a single index unit (one multiply-add) and the
// store's one read-modify-write path: after setup, each pixel goes through
// index, read and merge in turn (a clipped pixel skips the store read and
// the merge), and an outline sets up each edge after the first anew. A
// finished result waits in an output register, so the next command is taken
// while it is still pending.

module nibble_framebuffer_draw_engine #(
   parameter int STORE_BYTES = 65536
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_stall,
   input  nfde_pkg::req_type                req_data,

   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output nfde_pkg::rsp_type                rsp_data,

   input  logic                             csr_wr_en,
   input  logic [nfde_pkg::LW_W-1:0]        csr_wr_data
);

   import nfde_pkg::*;

   localparam int ADDR_W = $clog2(STORE_BYTES);
   localparam logic [ADDR_W-1:0] CLEAR_LAST  = ADDR_W'(STORE_BYTES - 1);
   localparam logic [IDX_W-1:0]  STORE_LIMIT = IDX_W'(STORE_BYTES);

   // Sequencer states
   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_SETUP = 3'd2;
   localparam logic [2:0] S_INDEX = 3'd3;
   localparam logic [2:0] S_READ  = 3'd4;
   localparam logic [2:0] S_MERGE = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   logic [2:0]         state_ff, state_in;
   logic [ADDR_W-1:0]  clr_ff, clr_in;
   logic [LW_W-1:0]    lw_ff, lw_in;

   // Held command
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [COORD_W-1:0] px_ff, px_in;
   logic [COORD_W-1:0] py_ff, py_in;
   logic [COORD_W-1:0] sw_ff, sw_in;
   logic [COORD_W-1:0] sh_ff, sh_in;
   logic [COLOR_W-1:0] color_ff, color_in;

   // Scan box of the current segment and the pixel cursor
   logic [1:0]         seg_ff, seg_in;
   logic               last_seg_ff, last_seg_in;
   logic [END_W-1:0]   x0_ff, x0_in;
   logic [END_W-1:0]   x1_ff, x1_in;
   logic [END_W-1:0]   y1_ff, y1_in;
   logic [END_W-1:0]   cur_x_ff, cur_x_in;
   logic [END_W-1:0]   cur_y_ff, cur_y_in;

   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               clip_ff, clip_in;
   logic [COLOR_W-1:0] pix_ff, pix_in;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   // Segment box decode
   logic [END_W-1:0]   px_ext, py_ext, x_end, y_end;
   logic [END_W-1:0]   box_x0, box_x1, box_y0, box_y1;
   logic               box_last;

   // Index unit, range check and merge
   logic [IDX_W-1:0]   prod;
   logic [IDX_W-2:0]   byte_idx;
   logic               in_range;
   logic               high_nib;
   logic [7:0]         rd_byte;
   logic [7:0]         merged;

   // Store port
   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   logic [7:0]         ram_wr_data;
   logic               ram_rd_en;

   logic               req_take;
   logic               rsp_free;
   logic               pixel_done;

   assign px_ext = END_W'(px_ff);
   assign py_ext = END_W'(py_ff);
   assign x_end  = px_ext + END_W'(sw_ff);
   assign y_end  = py_ext + END_W'(sh_ff);

   // Every command is a list of rectangular scans; lines and points are
   // degenerate boxes, an outline is its two columns then its two rows
   always_comb begin
      box_x0   = px_ext;
      box_x1   = px_ext;
      box_y0   = py_ext;
      box_y1   = py_ext;
      box_last = 1'b1;
      unique case (kind_ff) inside
         KIND_HLINE: begin
            box_x1 = x_end;
         end
         KIND_VLINE: begin
            box_y1 = y_end;
         end
         KIND_FILL: begin
            box_x1 = x_end;
            box_y1 = y_end;
         end
         KIND_OUTLINE: begin
            box_last = 1'b0;
            case (seg_ff)
               2'd0: begin
                  box_y1 = y_end;
               end
               2'd1: begin
                  box_x0 = x_end;
                  box_x1 = x_end;
                  box_y1 = y_end;
               end
               2'd2: begin
                  box_x1 = x_end;
               end
               default: begin
                  box_x1   = x_end;
                  box_y0   = y_end;
                  box_y1   = y_end;
                  box_last = 1'b1;
               end
            endcase
         end
         default: begin
            // point and read: one pixel at the start position
         end
      endcase
   end

   // Shared index unit: one multiply-add per pixel
   assign prod     = IDX_W'(cur_y_ff) * IDX_W'(lw_ff);
   assign byte_idx = idx_ff[IDX_W-1:1];
   assign in_range = {1'b0, byte_idx} < STORE_LIMIT;
   assign high_nib = idx_ff[0];
   assign merged   = high_nib ? {color_ff, rd_byte[3:0]} : {rd_byte[7:4], color_ff};

   assign req_take   = (state_ff == S_IDLE) && req_valid;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign pixel_done = ((state_ff == S_READ) && !in_range) || (state_ff == S_MERGE);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      lw_in        = csr_wr_en ? csr_wr_data : lw_ff;
      kind_in      = kind_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      sw_in        = sw_ff;
      sh_in        = sh_ff;
      color_in     = color_ff;
      seg_in       = seg_ff;
      last_seg_in  = last_seg_ff;
      x0_in        = x0_ff;
      x1_in        = x1_ff;
      y1_in        = y1_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      idx_in       = idx_ff;
      clip_in      = clip_ff;
      pix_in       = pix_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = byte_idx[ADDR_W-1:0];
      ram_wr_data  = merged;
      ram_rd_en    = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            // Zero the store one byte a cycle
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = '0;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == CLEAR_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_take) begin
               kind_in  = req_data.kind;
               px_in    = req_data.pos_x;
               py_in    = req_data.pos_y;
               sw_in    = req_data.span_w;
               sh_in    = req_data.span_h;
               color_in = req_data.color;
               seg_in   = '0;
               clip_in  = 1'b0;
               pix_in   = '0;
               // Unused codes draw nothing and answer at once
               state_in = (req_data.kind > KIND_READ) ? S_OUT : S_SETUP;
            end
         end
         S_SETUP: begin
            x0_in       = box_x0;
            x1_in       = box_x1;
            y1_in       = box_y1;
            cur_x_in    = box_x0;
            cur_y_in    = box_y0;
            last_seg_in = box_last;
            state_in    = S_INDEX;
         end
         S_INDEX: begin
            idx_in   = prod + IDX_W'(cur_x_ff);
            state_in = S_READ;
         end
         S_READ: begin
            // Pixels beyond the store are skipped and flagged
            if (in_range) begin
               ram_rd_en = 1'b1;
               state_in  = S_MERGE;
            end else begin
               clip_in = 1'b1;
            end
         end
         S_MERGE: begin
            if (kind_ff == KIND_READ) begin
               pix_in = high_nib ? rd_byte[7:4] : rd_byte[3:0];
            end else begin
               ram_wr_en = 1'b1;
            end
         end
         S_OUT: begin
            if (rsp_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.pixel_value = pix_ff;
               rsp_data_in.clipped     = clip_ff;
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Advance the cursor: along the row, then down, then to the next segment
      if (pixel_done) begin
         if (cur_x_ff != x1_ff) begin
            cur_x_in = cur_x_ff + 1'b1;
            state_in = S_INDEX;
         end else if (cur_y_ff != y1_ff) begin
            cur_x_in = x0_ff;
            cur_y_in = cur_y_ff + 1'b1;
            state_in = S_INDEX;
         end else if (last_seg_ff) begin
            state_in = S_OUT;
         end else begin
            seg_in   = seg_ff + 1'b1;
            state_in = S_SETUP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         lw_ff        <= LINE_WIDTH_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         lw_ff        <= lw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      sw_ff       <= sw_in;
      sh_ff       <= sh_in;
      color_ff    <= color_in;
      seg_ff      <= seg_in;
      last_seg_ff <= last_seg_in;
      x0_ff       <= x0_in;
      x1_ff       <= x1_in;
      y1_ff       <= y1_in;
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      idx_ff      <= idx_in;
      clip_ff     <= clip_in;
      pix_ff      <= pix_in;
      rsp_data_ff <= rsp_data_in;
   end

   nfde_ram #(
      .WIDTH (8),
      .DEPTH (STORE_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (byte_idx[ADDR_W-1:0]),
      .rd_data (rd_byte)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
